[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Request and response payloads, decoded command kinds, status codes and
// the ring geometry; every file of the block but deq_ram imports it.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Ring geometry (power of two, so index wrap is plain truncation)
   localparam int DEQ_DEPTH  = 16;
   localparam int DEQ_IDX_W  = $clog2(DEQ_DEPTH);
   localparam int DEQ_CNT_W  = $clog2(DEQ_DEPTH + 1);
   localparam int DEQ_WORD_W = 32;
   localparam int DEQ_OP_W   = 3;
   localparam int DEQ_STAT_W = 2;

   // Request opcodes
   localparam logic [DEQ_OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [DEQ_OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [DEQ_OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [DEQ_OP_W-1:0] OP_POP_BACK   = 3'd3;

   // Response status codes
   localparam logic [DEQ_STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [DEQ_STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
   localparam logic [DEQ_STAT_W-1:0] STAT_DROPPED   = 2'd2;

   // Decoded command kind
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_PUSH_FRONT,
      KIND_PUSH_BACK,
      KIND_POP_FRONT,
      KIND_POP_BACK
   } deq_kind_type;

   typedef struct packed {
      logic [DEQ_OP_W-1:0]          opcode;
      logic signed [DEQ_WORD_W-1:0] value;
   } deq_req_type;

   typedef struct packed {
      logic signed [DEQ_WORD_W-1:0] front_word;
      logic signed [DEQ_WORD_W-1:0] back_word;
      logic [DEQ_CNT_W-1:0]         entry_count;
      logic                         is_empty;
      logic                         is_full;
      logic [DEQ_STAT_W-1:0]        status;
   } deq_rsp_type;

   // Command handed from the front end to the executor
   typedef struct packed {
      deq_kind_type                 kind;
      logic signed [DEQ_WORD_W-1:0] value;
   } deq_cmd_type;

endpackage

[rtl/deq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: generic RAM, one write port, two registered read ports
// Read data updates only when rd_en is high and holds otherwise.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

[rtl/deq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_front: request intake and decode
// Accepts requests, decodes the opcode into a command kind and holds the
// commands in a two-entry queue for the executor.
// ----------------------------------------------------------------------------
module deq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  deq_pkg::deq_req_type req_data,
   output logic                 cmd_valid,
   output deq_pkg::deq_cmd_type cmd_data,
   input  logic                 cmd_take
);
   import deq_pkg::*;

   deq_cmd_type slot_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  fill_ff;
   logic [1:0]  fill_in;
   logic        push_xfer;
   logic        pop_xfer;
   deq_cmd_type decoded;

   // Opcode decode; unused codes behave as a no-op
   always_comb begin
      decoded.value = req_data.value;
      unique case (req_data.opcode)
         OP_PUSH_FRONT: decoded.kind = KIND_PUSH_FRONT;
         OP_PUSH_BACK:  decoded.kind = KIND_PUSH_BACK;
         OP_POP_FRONT:  decoded.kind = KIND_POP_FRONT;
         OP_POP_BACK:   decoded.kind = KIND_POP_BACK;
         default:       decoded.kind = KIND_NOP;
      endcase
   end

   assign req_full  = fill_ff[1];
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push_xfer = req_push & ~req_full;
   assign pop_xfer  = cmd_take & cmd_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push_xfer ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_xfer ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_xfer && !pop_xfer) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop_xfer && !push_xfer) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/deq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_back: command executor
// Updates head and count, writes the slot RAM, reads the front and back
// words and loads the response register.
// ----------------------------------------------------------------------------
module deq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  deq_pkg::deq_cmd_type cmd_data,
   output logic                 cmd_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output deq_pkg::deq_rsp_type rsp_data
);
   import deq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } deq_state_type;

   deq_state_type          state_ff;
   deq_state_type          state_in;
   logic [DEQ_IDX_W-1:0]   head_ff;
   logic [DEQ_IDX_W-1:0]   head_in;
   logic [DEQ_CNT_W-1:0]   count_ff;
   logic [DEQ_CNT_W-1:0]   count_in;
   logic [DEQ_STAT_W-1:0]  status_ff;
   logic [DEQ_STAT_W-1:0]  status_in;
   deq_rsp_type            rsp_ff;
   deq_rsp_type            rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   is_full;
   logic                   is_empty;
   logic                   wr_en;
   logic [DEQ_IDX_W-1:0]   wr_addr;
   logic                   rd_en;
   logic [DEQ_IDX_W-1:0]   tail_addr;
   logic [DEQ_WORD_W-1:0]  front_raw;
   logic [DEQ_WORD_W-1:0]  back_raw;
   logic                   rsp_free;

   assign is_full   = (count_ff == DEQ_CNT_W'(DEQ_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign tail_addr = head_ff + count_ff[DEQ_IDX_W-1:0] - DEQ_IDX_W'(1);
   assign rsp_free  = ~rsp_valid_ff | rsp_pop;
   assign cmd_take  = (state_ff == ST_IDLE) & cmd_valid;
   assign rd_en     = (state_ff == ST_READ);

   // Execute: pointer/count update and slot write
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      if (cmd_take) begin
         status_in = STAT_DONE;
         unique case (cmd_data.kind)
            KIND_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STAT_DROPPED;
               end else begin
                  head_in  = head_ff - DEQ_IDX_W'(1);
                  wr_addr  = head_ff - DEQ_IDX_W'(1);
                  wr_en    = 1'b1;
                  count_in = count_ff + DEQ_CNT_W'(1);
               end
            end
            KIND_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STAT_DROPPED;
               end else begin
                  wr_addr  = head_ff + count_ff[DEQ_IDX_W-1:0];
                  wr_en    = 1'b1;
                  count_in = count_ff + DEQ_CNT_W'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STAT_UNDERFLOW;
               end else begin
                  head_in  = head_ff + DEQ_IDX_W'(1);
                  count_in = count_ff - DEQ_CNT_W'(1);
               end
            end
            KIND_POP_BACK: begin
               if (is_empty) begin
                  status_in = STAT_UNDERFLOW;
               end else begin
                  count_in = count_ff - DEQ_CNT_W'(1);
               end
            end
            default: begin
               status_in = STAT_DONE;
            end
         endcase
      end
   end

   // Sequencer: execute, read, then load the response
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_take) state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Response register
   always_comb begin
      rsp_in.front_word  = is_empty ? '0 : front_raw;
      rsp_in.back_word   = is_empty ? '0 : back_raw;
      rsp_in.entry_count = count_ff;
      rsp_in.is_empty    = is_empty;
      rsp_in.is_full     = is_full;
      rsp_in.status      = status_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_pop;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         status_ff    <= STAT_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Word storage
   deq_ram #(
      .WIDTH (DEQ_WORD_W),
      .DEPTH (DEQ_DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (cmd_data.value),
      .rd_en     (rd_en),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_addr),
      .rd_data_a (front_raw),
      .rd_data_b (back_raw)
   );

endmodule

[rtl/double_ended_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of 32-bit words
//
// Requests enter through a queue-style port: an operation transfers at a
// clock edge with req_push high and req_full low. Each request carries an
// opcode (push front, push back, pop front, pop back, no-op) and a word.
// Every request gives exactly one response on the rsp_ port: front and back
// words (0 when empty), count, empty/full flags and a status. A response is
// on rsp_data while rsp_empty is low and transfers when rsp_pop is high.
//
// A response is loaded after its request passes the command queue and the
// executor sequence of update/write, registered RAM read, response load;
// the executor finishes one request before it takes the next.
// A two-entry command queue sits in front of the executor.
// Reset clears head, count, both queues and the response valid flag; the
// 16 word slots are not cleared and reach a response only once written.
// If the receiver stalls, the response holds, the executor waits and the
// command queue fills until req_full rises.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output deq_pkg::deq_rsp_type rsp_data
);
   import deq_pkg::*;

   logic        cmd_valid;
   logic        cmd_take;
   deq_cmd_type cmd_data;

   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   deq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/deq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the top-level ports only; attached by the bind at the bottom.
// ----------------------------------------------------------------------------
module deq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input deq_pkg::deq_rsp_type rsp_data
);
   import deq_pkg::*;

   // No response is pending right after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");

   // A stalled response keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

   // A dropped push only happens on a full queue
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STAT_DROPPED) |->
      (rsp_data.is_full && rsp_data.entry_count == DEQ_CNT_W'(DEQ_DEPTH)))
      else $error("push dropped while not full");

   // An ignored pop only happens on an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STAT_UNDERFLOW) |->
      (rsp_data.is_empty && rsp_data.entry_count == '0))
      else $error("pop ignored while not empty");

   // An empty queue reports zero words
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.is_empty) |->
      (rsp_data.front_word == '0 && rsp_data.back_word == '0))
      else $error("empty queue reported a word");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
